### sv/bse_pkg.sv
// Shared types and constants of the Burning Ship escape-time unit.
package bse_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 2'd0,
    CFG_CENTER_Y   = 2'd1,
    CFG_PIXEL_STEP = 2'd2,
    CFG_MAX_ITER   = 2'd3
  } cfg_idx_e;

  // Reset values of the pixel step and the iteration limit.
  localparam logic [63:0] STEP_RESET     = 64'd70368744177;
  localparam logic [63:0] MAX_ITER_RESET = 64'd96;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFF_MUL,
    ST_OFF_SUM,
    ST_COORD,
    ST_MUL,
    ST_SUM,
    ST_UPDATE,
    ST_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath and the output register.
  typedef struct packed {
    logic load_in;
    logic setup;
    logic init;
    logic step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic far;
    logic stop;
  } stat_t;

endpackage

### sv/bse_mul.sv
// Two-stage unsigned multiplier lane built from four half-width partial products.
module bse_mul #(
  parameter int OW = 47
) (
  input  logic            clk_i,
  input  logic [OW-1:0]   x_i,
  input  logic [OW-1:0]   y_i,
  output logic [2*OW-1:0] p_o
);

  localparam int H  = (OW + 1) / 2;
  localparam int HW = OW - H;
  localparam int PW = 2 * OW;

  logic [H-1:0]    xl, yl;
  logic [HW-1:0]   xh, yh;
  logic [2*H-1:0]  ll_d, ll_q;
  logic [OW-1:0]   lh_d, lh_q, hl_d, hl_q;
  logic [2*HW-1:0] hh_d, hh_q;
  logic [PW-1:0]   p_d, p_q;

  assign xl = x_i[H-1:0];
  assign xh = x_i[OW-1:H];
  assign yl = y_i[H-1:0];
  assign yh = y_i[OW-1:H];

  assign ll_d = (2*H)'(xl) * (2*H)'(yl);
  assign lh_d = OW'(xl) * OW'(yh);
  assign hl_d = OW'(xh) * OW'(yl);
  assign hh_d = (2*HW)'(xh) * (2*HW)'(yh);

  // Second stage adds the aligned partial products.
  assign p_d = PW'(ll_q) + (PW'(lh_q) << H) + (PW'(hl_q) << H) + (PW'(hh_q) << (2*H));

  always_ff @(posedge clk_i) begin
    ll_q <= ll_d;
    lh_q <= lh_d;
    hl_q <= hl_d;
    hh_q <= hh_d;
    p_q  <= p_d;
  end

  assign p_o = p_q;

endmodule

### sv/bse_dp.sv
// Datapath: pixel coordinate setup, the escape iteration and the iteration counter.
module bse_dp #(
  parameter int CW  = 48,
  parameter int PIX = 10,
  parameter int IW  = 21
) (
  input  logic                  clk_i,
  input  bse_pkg::cmd_t         cmd_i,
  output bse_pkg::stat_t        stat_o,
  input  logic signed [PIX-1:0] col_i,
  input  logic signed [PIX-1:0] row_i,
  input  logic signed [CW-1:0]  center_x_i,
  input  logic signed [CW-1:0]  center_y_i,
  input  logic [CW-2:0]         step_i,
  input  logic [IW-1:0]         max_iter_i,
  output logic [IW-1:0]         count_o,
  output logic                  escaped_o
);

  import bse_pkg::*;

  localparam int F  = CW - 4;
  localparam int OW = CW - 1;
  localparam int MW = CW - 2;
  localparam int PW = 2 * OW;
  localparam int EW = OW + PIX + 2;
  localparam int UW = CW + 1;

  localparam logic [EW-1:0] NEAR = EW'(9) << (F - 2);
  localparam logic [UW-1:0] TWO  = UW'(2) << F;
  localparam logic [UW-1:0] FOUR = UW'(4) << F;

  logic                  col_neg_q, row_neg_q;
  logic [PIX-1:0]        col_mag_q, row_mag_q;
  logic signed [OW-1:0]  cr_q, ci_q;
  logic [MW-1:0]         a_q, b_q;
  logic [IW-1:0]         count_q;
  logic                  first_q;

  logic [OW-1:0]         x0, y0, x1, y1, x2, y2;
  logic [PW-1:0]         p0, p1, p2;

  logic signed [EW-1:0]  cx, cy;
  logic                  near_r, near_i;
  logic [CW-1:0]         sa, sb, tp;
  logic signed [UW-1:0]  an, bn;
  logic [UW-1:0]         am, bm, sq;
  logic                  big, sq_esc, limit;
  logic [IW-1:0]         cnt_inc;

  // Exact centre plus signed offset, wide enough for any offset product.
  function automatic logic signed [EW-1:0] coord_sum(logic signed [CW-1:0] centre,
                                                     logic neg, logic [PW-1:0] prod);
    logic signed [EW-1:0] off;
    off = $signed({2'b00, prod[OW+PIX-1:0]});
    return EW'(centre) + (neg ? -off : off);
  endfunction

  function automatic logic [MW-1:0] mag_of(logic signed [EW-1:0] v);
    return v[EW-1] ? MW'(-v) : MW'(v);
  endfunction

  // During setup the lanes form |col|*step and |row|*step; in the loop a*a, b*b, 2a*b.
  always_comb begin
    if (cmd_i.setup) begin
      x0 = OW'(col_mag_q);
      y0 = step_i;
      x1 = OW'(row_mag_q);
      y1 = step_i;
    end else begin
      x0 = OW'(a_q);
      y0 = OW'(a_q);
      x1 = OW'(b_q);
      y1 = OW'(b_q);
    end
    x2 = {a_q, 1'b0};
    y2 = OW'(b_q);
  end

  bse_mul #(.OW(OW)) u_mul_a (.clk_i(clk_i), .x_i(x0), .y_i(y0), .p_o(p0));
  bse_mul #(.OW(OW)) u_mul_b (.clk_i(clk_i), .x_i(x1), .y_i(y1), .p_o(p1));
  bse_mul #(.OW(OW)) u_mul_t (.clk_i(clk_i), .x_i(x2), .y_i(y2), .p_o(p2));

  assign cx     = coord_sum(center_x_i, col_neg_q, p0);
  assign cy     = coord_sum(center_y_i, row_neg_q, p1);
  assign near_r = (cx < $signed(NEAR)) && (cx > -$signed(NEAR));
  assign near_i = (cy < $signed(NEAR)) && (cy > -$signed(NEAR));

  // Products truncated to F fraction bits.
  assign sa = p0[F +: CW];
  assign sb = p1[F +: CW];
  assign tp = p2[F +: CW];

  assign an = $signed({1'b0, sa}) - $signed({1'b0, sb}) + UW'(cr_q);
  assign bn = $signed({1'b0, tp}) - UW'(ci_q);
  assign am = an[UW-1] ? UW'(-an) : UW'(an);
  assign bm = bn[UW-1] ? UW'(-bn) : UW'(bn);
  assign sq = {1'b0, sa} + {1'b0, sb};

  assign big     = (am > TWO) || (bm > TWO);
  // The squared radius is checked for points produced by an iteration, not for c itself.
  assign sq_esc  = !first_q && (sq > FOUR);
  assign cnt_inc = count_q + 1'b1;
  assign limit   = cnt_inc >= max_iter_i;

  assign stat_o.far  = !(near_r && near_i);
  assign stat_o.stop = sq_esc || big || limit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      col_neg_q <= col_i[PIX-1];
      col_mag_q <= col_i[PIX-1] ? PIX'(-col_i) : PIX'(col_i);
      row_neg_q <= row_i[PIX-1];
      row_mag_q <= row_i[PIX-1] ? PIX'(-row_i) : PIX'(row_i);
    end
    if (cmd_i.init) begin
      cr_q    <= OW'(cx);
      ci_q    <= OW'(cy);
      a_q     <= mag_of(cx);
      b_q     <= mag_of(cy);
      count_q <= stat_o.far ? IW'(1) : '0;
      first_q <= 1'b1;
    end
    if (cmd_i.step && !sq_esc) begin
      count_q <= cnt_inc;
      a_q     <= am[MW-1:0];
      b_q     <= bm[MW-1:0];
      first_q <= 1'b0;
    end
  end

  assign count_o   = count_q;
  assign escaped_o = count_q < max_iter_i;

endmodule

### sv/bse_ctrl.sv
// Controller state machine that sequences setup, iterations and result hand-off.
module bse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_free_i,
  input  bse_pkg::stat_t stat_i,
  output bse_pkg::cmd_t  cmd_o
);

  import bse_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_OFF_MUL;
      ST_OFF_MUL: state_d = ST_OFF_SUM;
      ST_OFF_SUM: state_d = ST_COORD;
      ST_COORD:   state_d = stat_i.far ? ST_DONE : ST_MUL;
      ST_MUL:     state_d = ST_SUM;
      ST_SUM:     state_d = ST_UPDATE;
      ST_UPDATE:  state_d = stat_i.stop ? ST_DONE : ST_MUL;
      ST_DONE:    if (out_free_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_OFF_MUL: cmd_o.setup = 1'b1;
      ST_COORD:   cmd_o.init  = 1'b1;
      ST_UPDATE:  cmd_o.step  = 1'b1;
      ST_DONE:    cmd_o.out_load = out_free_i;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free_i)
    else $error("result loaded while the output register is occupied");

  a_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPDATE && !stat_i.stop |=> state_q == ST_MUL)
    else $error("iteration did not continue");

  a_setup_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.init |-> $past(state_q) == ST_OFF_SUM)
    else $error("coordinates formed before the offset products");
`endif

endmodule

### sv/burning_ship_escape_time.sv
// Top level of the Burning Ship escape-time pixel unit.
//
// Usage: each request on the slave stream is one pixel, given as a signed column
// and row offset from the image centre. The unit forms c = centre + offset * step
// in Q4.F fixed point, iterates z' = (a*a - b*b + cr, 2|a||b| - ci) from z = c and
// returns on the master stream the iteration count and an escaped flag, which is
// set when the count stayed below the iteration limit. One result per request.
// The configuration channel writes the centre, the pixel step and the limit; it
// is always ready and is meant to be written only while no pixel is in flight.
// One pixel is worked on at a time. After acceptance the offset products, their
// sum and the coordinate are formed in turn, then each iteration passes through
// the partial products, the product sum and the update. A pixel far outside
// skips the iterations. The squared-radius test uses the next iteration's
// products, so a loop that it ends runs one more iteration without counting it.
// The next request is taken in the cycle after the result enters the output
// register, even while it waits. If the receiver stalls, a finished second
// result waits in the datapath until the output register frees, and no new
// request is accepted meanwhile.
// Reset is asynchronous and active low: it empties the output register, returns
// the controller to idle and loads the register reset values.
module burning_ship_escape_time #(
  parameter int COORD_WIDTH = 48,
  parameter int HALF_SIZE   = 512,
  parameter int ITER_WIDTH  = 21,
  localparam int PIX_WIDTH  = $clog2(HALF_SIZE) + 1,
  localparam int IN_WIDTH   = ((2 * PIX_WIDTH + 7) / 8) * 8,
  localparam int OUT_WIDTH  = ((ITER_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Pixel requests.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // From bit 0: pixel_col, pixel_row, zero padding.
  input  logic [IN_WIDTH-1:0]            s_axis_tdata_i,
  // Results.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // From bit 0: iteration_count, escaped, zero padding.
  output logic [OUT_WIDTH-1:0]           m_axis_tdata_o,
  // Configuration writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COORD_WIDTH-1:0]         cfg_data_i
);

  import bse_pkg::*;

  logic signed [COORD_WIDTH-1:0] center_x_q, center_y_q;
  logic [COORD_WIDTH-2:0]        step_q;
  logic [ITER_WIDTH-1:0]         max_iter_q;

  logic                  out_valid_q, out_valid_d;
  logic [ITER_WIDTH-1:0] out_count_q;
  logic                  out_esc_q;
  logic                  out_free;

  cmd_t                  cmd;
  stat_t                 stat;
  logic [ITER_WIDTH-1:0] count;
  logic                  escaped;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      step_q     <= STEP_RESET[COORD_WIDTH-2:0];
      max_iter_q <= MAX_ITER_RESET[ITER_WIDTH-1:0];
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CENTER_X:   center_x_q <= cfg_data_i;
        CFG_CENTER_Y:   center_y_q <= cfg_data_i;
        CFG_PIXEL_STEP: step_q     <= cfg_data_i[COORD_WIDTH-2:0];
        CFG_MAX_ITER:   max_iter_q <= cfg_data_i[ITER_WIDTH-1:0];
        default:        ;
      endcase
    end
  end

  bse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bse_dp #(
    .CW  (COORD_WIDTH),
    .PIX (PIX_WIDTH),
    .IW  (ITER_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .col_i      ($signed(s_axis_tdata_i[PIX_WIDTH-1:0])),
    .row_i      ($signed(s_axis_tdata_i[2*PIX_WIDTH-1:PIX_WIDTH])),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .step_i     (step_q),
    .max_iter_i (max_iter_q),
    .count_o    (count),
    .escaped_o  (escaped)
  );

  // Output register: a finished result sits here until the receiver takes it.
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_count_q <= count;
      out_esc_q   <= escaped;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_WIDTH'({out_esc_q, out_count_q});

endmodule

### bench/burning_ship_escape_time_checker.sv
// Channel monitor, escape-count predictor and result comparison for the escape-time unit.
module burning_ship_escape_time_checker #(
  parameter int COORD_WIDTH = 48,
  parameter int HALF_SIZE   = 512,
  parameter int ITER_WIDTH  = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [23:0]                   s_axis_tdata_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [23:0]                   m_axis_tdata_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bse_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import bse_pkg::*;

  localparam int PIX_WIDTH = $clog2(HALF_SIZE) + 1;
  localparam int FRAC      = COORD_WIDTH - 4;
  localparam int NUM_WIDTH = COORD_WIDTH + PIX_WIDTH + 2;

  typedef logic signed [NUM_WIDTH-1:0] coord_t;
  typedef logic [2*NUM_WIDTH-1:0]      prod_t;

  typedef struct packed {
    logic [ITER_WIDTH-1:0] count;
    logic                  escaped;
    logic [PIX_WIDTH-1:0]  col;
    logic [PIX_WIDTH-1:0]  row;
  } pixel_result_t;

  // 2.25, 2 and 4 in the unit's fixed-point format.
  localparam coord_t NEAR_EDGE = coord_t'(9) << (FRAC - 2);
  localparam coord_t TWO       = coord_t'(2) << FRAC;
  localparam coord_t FOUR      = coord_t'(4) << FRAC;

  logic [COORD_WIDTH-1:0] center_x_q;
  logic [COORD_WIDTH-1:0] center_y_q;
  logic [COORD_WIDTH-2:0] step_q;
  logic [ITER_WIDTH-1:0]  max_iter_q;

  pixel_result_t expected_counts[$];
  pixel_result_t want;
  int            mismatches;
  int            outstanding;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t %m: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic coord_t magnitude(input coord_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Truncated fixed-point product of two non-negative values.
  function automatic coord_t frac_mul(input coord_t x, input coord_t y);
    prod_t p;
    p = prod_t'(x) * prod_t'(y);
    return coord_t'(p >> FRAC);
  endfunction

  function automatic coord_t pixel_coord(input logic [COORD_WIDTH-1:0] centre,
                                         input logic [PIX_WIDTH-1:0]   offset,
                                         input logic [COORD_WIDTH-2:0] spacing);
    coord_t c;
    coord_t o;
    coord_t s;
    c = coord_t'($signed(centre));
    o = coord_t'($signed(offset));
    s = coord_t'($signed({1'b0, spacing}));
    return c + o * s;
  endfunction

  function automatic pixel_result_t escape_count_of(input logic [PIX_WIDTH-1:0] col,
                                                    input logic [PIX_WIDTH-1:0] row);
    coord_t        cr;
    coord_t        ci;
    coord_t        re_mag;
    coord_t        im_mag;
    coord_t        re_next;
    coord_t        twice_ab;
    logic [63:0]   n;
    logic          gone;
    pixel_result_t r;
    cr = pixel_coord(center_x_q, col, step_q);
    ci = pixel_coord(center_y_q, row, step_q);
    n  = 64'd1;
    // A point at least 2.25 out on either axis gets a count of one without iterating.
    if (magnitude(cr) < NEAR_EDGE && magnitude(ci) < NEAR_EDGE) begin
      re_mag = magnitude(cr);
      im_mag = magnitude(ci);
      n      = 64'd0;
      do begin
        twice_ab = frac_mul(2 * re_mag, im_mag);
        re_next  = frac_mul(re_mag, re_mag) - frac_mul(im_mag, im_mag) + cr;
        re_mag   = magnitude(re_next);
        im_mag   = magnitude(twice_ab - ci);
        n++;
        gone = (re_mag > TWO) || (im_mag > TWO) ||
               (frac_mul(re_mag, re_mag) + frac_mul(im_mag, im_mag) > FOUR);
      end while (!gone && n < max_iter_q);
    end
    r.count   = n[ITER_WIDTH-1:0];
    r.escaped = (n < max_iter_q);
    r.col     = col;
    r.row     = row;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      step_q     <= STEP_RESET[COORD_WIDTH-2:0];
      max_iter_q <= MAX_ITER_RESET[ITER_WIDTH-1:0];
      expected_counts.delete();
      outstanding = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CENTER_X:   center_x_q <= cfg_data_i;
          CFG_CENTER_Y:   center_y_q <= cfg_data_i;
          CFG_PIXEL_STEP: step_q     <= cfg_data_i[COORD_WIDTH-2:0];
          CFG_MAX_ITER:   max_iter_q <= cfg_data_i[ITER_WIDTH-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_counts.push_back(escape_count_of(s_axis_tdata_i[PIX_WIDTH-1:0],
                                                  s_axis_tdata_i[2*PIX_WIDTH-1:PIX_WIDTH]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("result %h with no request outstanding", m_axis_tdata_i));
        end else begin
          want = expected_counts.pop_front();
          if (m_axis_tdata_i[ITER_WIDTH-1:0] !== want.count) begin
            report_mismatch($sformatf("pixel (%0d,%0d): count %0d, predicted %0d",
                                      $signed(want.col), $signed(want.row),
                                      m_axis_tdata_i[ITER_WIDTH-1:0], want.count));
          end
          if (m_axis_tdata_i[ITER_WIDTH] !== want.escaped) begin
            report_mismatch($sformatf("pixel (%0d,%0d): escaped %b, predicted %b",
                                      $signed(want.col), $signed(want.row),
                                      m_axis_tdata_i[ITER_WIDTH], want.escaped));
          end
        end
      end
      outstanding = expected_counts.size();
    end
  end

endmodule

### bench/burning_ship_escape_time_tb.sv
// Stimulus, clock, reset and verdict for the Burning Ship escape-time unit.
module burning_ship_escape_time_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bse_pkg::*;

  localparam int COORD_W = 48;
  localparam int HALF    = 512;
  localparam int ITER_W  = 21;
  localparam int PIX_W   = $clog2(HALF) + 1;
  localparam int IN_W    = ((2 * PIX_W + 7) / 8) * 8;
  localparam int OUT_W   = ((ITER_W + 1 + 7) / 8) * 8;
  localparam int FRAC    = COORD_W - 4;

  // One in the Q4.44 coordinate format.
  localparam longint FX_ONE = longint'(1) << FRAC;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 s_valid;
  logic                 s_ready;
  // From bit 0: pixel_col, pixel_row, zero padding.
  logic [IN_W-1:0]      s_data;
  logic                 m_valid;
  logic                 m_ready;
  // From bit 0: iteration_count, escaped, zero padding.
  logic [OUT_W-1:0]     m_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  int   mismatches;
  int   pending;
  // Set for the last phase: from then on neither side inserts idle cycles.
  logic calm_tail = 1'b0;

  always #5 clk = ~clk;

  burning_ship_escape_time dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  burning_ship_escape_time_checker #(
    .COORD_WIDTH (COORD_W),
    .HALF_SIZE   (HALF),
    .ITER_WIDTH  (ITER_W)
  ) escape_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (mismatches),
    .pending_o       (pending)
  );

  // Waits until every accepted pixel has delivered its result. The count is
  // sampled on the falling edge so it never races the checker's update.
  task automatic wait_idle();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Valid is left high after the handshake so that back-to-back writes never
  // lower and raise it in the same time step; the caller lowers it.
  task automatic write_reg(input cfg_idx_e idx, input logic [COORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Loads a full setting once the unit has gone quiet.
  task automatic apply_settings(input logic [COORD_W-1:0] cx,
                                input logic [COORD_W-1:0] cy,
                                input logic [COORD_W-2:0] spacing,
                                input logic [ITER_W-1:0]  limit);
    wait_idle();
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_PIXEL_STEP, COORD_W'(spacing));
    write_reg(CFG_MAX_ITER, COORD_W'(limit));
    cfg_valid <= 1'b0;
  endtask

  // Sends one pixel request, sometimes after a short idle burst. Valid stays
  // high afterwards; the next request or the end of a phase decides its level.
  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {{(IN_W - 2 * PIX_W){1'b0}}, row, col};
    do @(posedge clk); while (!s_ready);
  endtask

  // Centres mostly lie within +-2, where the interesting structure is; now
  // and then any 48-bit value, which puts most pixels far outside.
  function automatic logic [COORD_W-1:0] pick_center();
    longint v;
    if ($urandom_range(0, 5) == 0) begin
      v = {$urandom(), $urandom()};
    end else begin
      v = longint'($urandom_range(0, 4000)) - 2000;
      v = v * (FX_ONE / 1000);
    end
    return v[COORD_W-1:0];
  endfunction

  // Steps are mostly fine, so that whole windows stay near the set; the
  // degenerate and extreme spacings come up now and then.
  function automatic logic [COORD_W-2:0] pick_step();
    longint v;
    case ($urandom_range(0, 19))
      0:       v = 0;
      1:       v = 1;
      2:       v = -1;
      3:       v = {$urandom(), $urandom()};
      default: v = longint'($urandom_range(1, 4000)) * (FX_ONE / 100000);
    endcase
    return v[COORD_W-2:0];
  endfunction

  // Limits stay small so that points that never escape cost few cycles.
  function automatic logic [ITER_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return ITER_W'(2);
      1:       return ITER_W'(3);
      2:       return ITER_W'(5);
      3:       return ITER_W'(7);
      4:       return ITER_W'(17);
      5:       return ITER_W'(32);
      6:       return ITER_W'(64);
      7:       return ITER_W'(96);
      8:       return ITER_W'(128);
      default: return ITER_W'(160);
    endcase
  endfunction

  // The receiver mixes ready runs with stall bursts at random, and stays ready
  // throughout the last phase.
  initial begin : result_sink
    m_ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!calm_tail && $urandom_range(0, 2) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        m_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Hard stop well beyond the slowest legal run: about 1300 pixels, most at up
  // to 160 iterations each, plus stalls on both sides.
  initial begin : watchdog
    #(50_000_000);
    $display("burning_ship_escape_time_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned        phase;
    int unsigned        k;
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
    s_valid   <= 1'b0;
    s_data    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CENTER_X;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: the origin never escapes and runs to the limit; the
    // corners of the offset range sit just inside the far-point bound.
    send_pixel(PIX_W'(0), PIX_W'(0));
    send_pixel(PIX_W'(511), PIX_W'(511));
    send_pixel(PIX_W'(-512), PIX_W'(-512));
    send_pixel(PIX_W'(-512), PIX_W'(511));
    send_pixel(PIX_W'(511), PIX_W'(-512));
    send_pixel(PIX_W'(-1), PIX_W'(0));
    send_pixel(PIX_W'(100), PIX_W'(-80));
    s_valid <= 1'b0;

    // Centre at 2.5: the middle pixel is a far point, the left edge is not.
    apply_settings(COORD_W'(FX_ONE * 5 / 2), '0, (COORD_W - 1)'(64'd70368744177),
                   ITER_W'(96));
    send_pixel(PIX_W'(0), PIX_W'(0));
    send_pixel(PIX_W'(-512), PIX_W'(0));
    s_valid <= 1'b0;

    // Zero step maps every pixel to the centre; an odd limit stops exactly there.
    apply_settings('0, '0, '0, ITER_W'(7));
    send_pixel(PIX_W'(511), PIX_W'(-512));
    s_valid <= 1'b0;

    // Limits of one and zero still perform a single iteration.
    apply_settings('0, '0, '0, ITER_W'(1));
    send_pixel(PIX_W'(0), PIX_W'(0));
    s_valid <= 1'b0;
    apply_settings('0, '0, '0, ITER_W'(0));
    send_pixel(PIX_W'(3), PIX_W'(3));
    s_valid <= 1'b0;

    // Extreme centres and step. Offset (-1, 1) cancels them almost exactly.
    apply_settings({1'b0, {(COORD_W - 1){1'b1}}}, {1'b1, {(COORD_W - 1){1'b0}}},
                   '1, ITER_W'(2));
    send_pixel(PIX_W'(-1), PIX_W'(1));
    send_pixel(PIX_W'(0), PIX_W'(0));
    send_pixel(PIX_W'(-512), PIX_W'(511));
    s_valid <= 1'b0;

    // Largest limit: only points that escape, the first after a dozen or so
    // iterations along the real axis.
    apply_settings(COORD_W'(FX_ONE * 3 / 10), '0, (COORD_W - 1)'(FX_ONE / 16),
                   ITER_W'(1048608));
    send_pixel(PIX_W'(0), PIX_W'(0));
    send_pixel(PIX_W'(10), PIX_W'(0));
    send_pixel(PIX_W'(-100), PIX_W'(0));
    send_pixel(PIX_W'(0), PIX_W'(-40));
    s_valid <= 1'b0;

    // Random phases, each with its own setting.
    for (phase = 0; phase < 10; phase++) begin
      if (phase == 9) calm_tail = 1'b1;
      apply_settings(pick_center(), pick_center(), pick_step(), pick_limit());
      for (k = 0; k < 125; k++) begin
        if ($urandom_range(0, 1) == 0) begin
          col = PIX_W'($urandom_range(0, 1023));
          row = PIX_W'($urandom_range(0, 1023));
        end else begin
          // A window around the centre, where long iterations are likely.
          col = PIX_W'($urandom_range(0, 128) - 64);
          row = PIX_W'($urandom_range(0, 128) - 64);
        end
        send_pixel(col, row);
      end
      s_valid <= 1'b0;
    end

    // Drain, then allow time for any stray extra result to show up.
    wait_idle();
    repeat (32) @(posedge clk);
    if (mismatches == 0) begin
      $display("burning_ship_escape_time_tb OK");
    end else begin
      $display("burning_ship_escape_time_tb NOT OK");
    end
    $finish;
  end

endmodule

### burning_ship_escape_time.f
sv/bse_pkg.sv
sv/bse_mul.sv
sv/bse_dp.sv
sv/bse_ctrl.sv
sv/burning_ship_escape_time.sv
bench/burning_ship_escape_time_checker.sv
bench/burning_ship_escape_time_tb.sv
